/* rtl/core/bllp_pkg.sv */
// Shared types, constants and character helpers for the byte literal list parser.
package bllp_pkg;

  // Parse phase codes
  localparam logic [3:0] PH_ENTRY      = 4'd0;
  localparam logic [3:0] PH_ENTRY_NOTE = 4'd1;
  localparam logic [3:0] PH_LEAD_ZERO  = 4'd2;
  localparam logic [3:0] PH_NUMBER     = 4'd3;
  localparam logic [3:0] PH_LIT_OPEN   = 4'd4;
  localparam logic [3:0] PH_LIT_ESC    = 4'd5;
  localparam logic [3:0] PH_LIT_CLOSE  = 4'd6;
  localparam logic [3:0] PH_AFTER      = 4'd7;
  localparam logic [3:0] PH_AFTER_NOTE = 4'd8;

  // Radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  // Characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_B      = 8'h62;

  localparam logic [4:0]  NO_DIGIT = 5'd16;
  localparam logic [11:0] MAX_BYTE = 12'd255;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       syntax_error;
    logic       done_res;
  } bllp_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c inside {[8'h30:8'h39]}) begin
      d = 5'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      d = 5'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      d = 5'(c - 8'h37);
    end
    return d;
  endfunction

  function automatic logic [4:0] base_of(input logic [1:0] radix);
    logic [4:0] b;
    case (radix)
      RADIX_OCT: b = 5'd8;
      RADIX_HEX: b = 5'd16;
      RADIX_BIN: b = 5'd2;
      default:   b = 5'd10;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] escape_of(input logic [7:0] c);
    logic [7:0] e;
    case (c)
      8'h30:   e = 8'h00;  // 0
      8'h61:   e = 8'h07;  // a
      8'h65:   e = 8'h1b;  // e
      8'h66:   e = 8'h0c;  // f
      8'h6e:   e = 8'h0a;  // n
      8'h72:   e = 8'h0d;  // r
      8'h74:   e = 8'h09;  // t
      8'h76:   e = 8'h0b;  // v
      default: e = c;
    endcase
    return e;
  endfunction

endpackage

/* rtl/core/bllp_if.sv */
// Handshake channel interfaces for the parser's character input and byte output.
interface bllp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface bllp_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic       syntax_error;
  logic       done_res;

  modport source (output valid, output byte_valid, output byte_value,
                  output syntax_error, output done_res, input ready);
  modport sink (input valid, input byte_valid, input byte_value,
                input syntax_error, input done_res, output ready);
endinterface

/* rtl/core/byte_literal_list_parser.sv */
// Latency: a result word shows on out_o in the cycle after its character is accepted, once
// the words ahead of it have left the queue.
// Throughput: one character per cycle unless the queue is full; one registered parse step.
// A two-entry output queue keeps in_i ready while one result word waits on a stalled sink.
// Characters that cause no result leave nothing in the queue.
// Reset (rst_ni low, asynchronous) clears the parse state, the error flag and the queue.
module byte_literal_list_parser
  import bllp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bllp_in_if.sink    in_i,
  bllp_out_if.source out_o
);

  logic      accept;
  logic      res_valid;
  bllp_res_t res;

  logic      v0_q, v0_d, v1_q, v1_d;
  bllp_res_t s0_q, s0_d, s1_q, s1_d;
  logic      push, pop;

  assign in_i.ready = ~v1_q;
  assign accept     = in_i.valid & ~v1_q;

  bllp_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .ch_i          (in_i.ch),
    .end_of_text_i (in_i.end_of_text),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign push = accept & res_valid;
  assign pop  = v0_q & out_o.ready;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    s0_d = s0_q;
    s1_d = s1_q;
    if (!v0_q) begin
      if (push) begin
        s0_d = res;
        v0_d = 1'b1;
      end
    end else if (!v1_q) begin
      if (pop && push) begin
        s0_d = res;
      end else if (pop) begin
        v0_d = 1'b0;
      end else if (push) begin
        s1_d = res;
        v1_d = 1'b1;
      end
    end else if (pop) begin
      // advance the waiting word to the head
      s0_d = s1_q;
      v1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign out_o.valid        = v0_q;
  assign out_o.byte_valid   = s0_q.byte_valid;
  assign out_o.byte_value   = s0_q.byte_value;
  assign out_o.syntax_error = s0_q.syntax_error;
  assign out_o.done_res     = s0_q.done_res;

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q)
    else $error("second queue slot filled while head is empty");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !out_o.ready |=> v1_q && $stable(s1_q))
    else $error("waiting word lost while sink stalls");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !v0_q |=> v0_q && (s0_q == $past(res)))
    else $error("result word not captured at head");

endmodule

/* rtl/core/bllp_fsm.sv */
// Parse state registers and the per-character next-state and result logic.
module bllp_fsm
  import bllp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] ch_i,
  input  logic       end_of_text_i,
  output logic       res_valid_o,
  output bllp_res_t  res_o
);

  logic [3:0] ph_q, ph_d;
  logic [7:0] acc_q, acc_d;
  logic [1:0] rad_q, rad_d;
  logic       saw_q, saw_d;
  logic       fail_q, fail_d;

  logic        err;
  logic        have_byte;
  logic [7:0]  byte_out;
  logic        do_num;
  logic        do_after;
  logic [4:0]  dig;
  logic [4:0]  base;
  logic [11:0] scaled;
  logic [11:0] next_val;

  always_comb begin
    ph_d      = ph_q;
    acc_d     = acc_q;
    rad_d     = rad_q;
    saw_d     = saw_q;
    fail_d    = fail_q;
    err       = 1'b0;
    have_byte = 1'b0;
    byte_out  = 8'h00;
    do_num    = 1'b0;
    do_after  = 1'b0;
    dig       = digit_of(ch_i);
    base      = 5'd10;
    scaled    = 12'd0;
    next_val  = 12'd0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i && end_of_text_i) begin
      // flush the open entry, then return to reset
      if (!fail_q) begin
        case (ph_q)
          PH_LEAD_ZERO: begin
            have_byte = 1'b1;
          end
          PH_NUMBER: begin
            if (saw_q) begin
              have_byte = 1'b1;
              byte_out  = acc_q;
            end else begin
              err = 1'b1;
            end
          end
          PH_LIT_OPEN, PH_LIT_ESC, PH_LIT_CLOSE: begin
            err = 1'b1;
          end
          default: begin
          end
        endcase
      end
      res_valid_o        = 1'b1;
      res_o.byte_valid   = have_byte;
      res_o.byte_value   = have_byte ? byte_out : 8'h00;
      res_o.syntax_error = fail_q | err;
      res_o.done_res     = 1'b1;
      ph_d   = PH_ENTRY;
      acc_d  = 8'h00;
      rad_d  = RADIX_DEC;
      saw_d  = 1'b0;
      fail_d = 1'b0;
    end else if (accept_i && !fail_q) begin
      case (ph_q)
        PH_ENTRY_NOTE: begin
          if (ch_i == CH_NL) ph_d = PH_ENTRY;
        end
        PH_LEAD_ZERO: begin
          ph_d = PH_NUMBER;
          if (ch_i == CH_X) begin
            rad_d = RADIX_HEX;
          end else if (ch_i == CH_B) begin
            rad_d = RADIX_BIN;
          end else begin
            rad_d  = RADIX_OCT;
            saw_d  = 1'b1;
            do_num = 1'b1;
          end
        end
        PH_NUMBER: begin
          do_num = 1'b1;
        end
        PH_LIT_OPEN: begin
          if (ch_i == CH_BSLASH) begin
            ph_d = PH_LIT_ESC;
          end else begin
            acc_d = ch_i;
            ph_d  = PH_LIT_CLOSE;
          end
        end
        PH_LIT_ESC: begin
          acc_d = escape_of(ch_i);
          ph_d  = PH_LIT_CLOSE;
        end
        PH_LIT_CLOSE: begin
          if (ch_i == CH_QUOTE) begin
            have_byte = 1'b1;
            byte_out  = acc_q;
            ph_d      = PH_AFTER;
          end else begin
            err = 1'b1;
          end
        end
        PH_AFTER: begin
          do_after = 1'b1;
        end
        PH_AFTER_NOTE: begin
          if (ch_i == CH_NL) ph_d = PH_AFTER;
        end
        default: begin
          // expect entry; unused codes land here too
          ph_d = PH_ENTRY;
          if (is_space(ch_i)) begin
          end else if (ch_i == CH_HASH) begin
            ph_d = PH_ENTRY_NOTE;
          end else if (ch_i == CH_QUOTE) begin
            ph_d = PH_LIT_OPEN;
          end else begin
            acc_d = 8'h00;
            saw_d = 1'b0;
            rad_d = RADIX_DEC;
            if (ch_i == CH_ZERO) begin
              ph_d = PH_LEAD_ZERO;
            end else if (dig == NO_DIGIT) begin
              err = 1'b1;
            end else begin
              ph_d   = PH_NUMBER;
              do_num = 1'b1;
            end
          end
        end
      endcase

      // one digit step or the end of a number
      if (do_num) begin
        base = base_of(rad_d);
        case (rad_d)
          RADIX_OCT: scaled = {1'b0, acc_d, 3'b000};
          RADIX_HEX: scaled = {acc_d, 4'b0000};
          RADIX_BIN: scaled = {3'b000, acc_d, 1'b0};
          default:   scaled = {1'b0, acc_d, 3'b000} + {3'b000, acc_d, 1'b0};
        endcase
        next_val = scaled + {7'd0, dig};
        if (dig == NO_DIGIT) begin
          if (!saw_d) begin
            err = 1'b1;
          end else begin
            have_byte = 1'b1;
            byte_out  = acc_d;
            ph_d      = PH_AFTER;
            do_after  = 1'b1;
          end
        end else if (dig >= base || next_val > MAX_BYTE) begin
          err = 1'b1;
        end else begin
          acc_d = next_val[7:0];
          saw_d = 1'b1;
        end
      end

      if (do_after) begin
        if (is_space(ch_i)) begin
        end else if (ch_i == CH_HASH) begin
          ph_d = PH_AFTER_NOTE;
        end else if (ch_i == CH_COMMA) begin
          ph_d = PH_ENTRY;
        end else begin
          err = 1'b1;
        end
      end

      if (err) fail_d = 1'b1;
      // drop a byte whose ending character is itself faulty
      res_valid_o        = have_byte | err;
      res_o.byte_valid   = have_byte & ~err;
      res_o.byte_value   = (have_byte && !err) ? byte_out : 8'h00;
      res_o.syntax_error = err;
      res_o.done_res     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_ENTRY;
      acc_q  <= 8'h00;
      rad_q  <= RADIX_DEC;
      saw_q  <= 1'b0;
      fail_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      acc_q  <= acc_d;
      rad_q  <= rad_d;
      saw_q  <= saw_d;
      fail_q <= fail_d;
    end
  end

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q && !(accept_i && end_of_text_i) |=> fail_q)
    else $error("error flag cleared before end of text");

  a_eot_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_text_i |=> (ph_q == PH_ENTRY) && !fail_q && !saw_q)
    else $error("state not returned to reset after end of text");

  a_silent_when_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q && accept_i && !end_of_text_i |-> !res_valid_o)
    else $error("result given while error flag set");

  a_byte_excludes_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.byte_valid && res_o.syntax_error))
    else $error("byte delivered together with error");

endmodule
